[hdl/selp_pkg.sv]
// Shared types and constants for the scaled exponential low-pass filter.
// No dependencies.
package selp_pkg;

  localparam int unsigned SCALE       = 1000;
  localparam int unsigned WEIGHT_BITS = 10;
  localparam int unsigned DVSR_W      = WEIGHT_BITS + 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV1 = 5'b00100,
    ST_DIV2 = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  typedef struct packed {
    logic [DVSR_W-1:0] rem;
    logic              qbit;
  } div_step_t;

endpackage

[hdl/scaled_exponential_lowpass.sv]
// Scaled exponential low-pass filter: top level with its sequencer and shared divider.
// Depends on selp_pkg.
//
// Each sample word updates a running value kept at 1000 times the sample scale:
// new = (w * old + 1000 * sample) / (w + 1), truncated, and the block returns
// new / 1000, truncated. The weight w (0..1023) is written through
// smoothing_weight_we / smoothing_weight; the user must do so only while the block
// is idle, as the block does not enforce it. w = 0 passes samples straight through.
// Per sample, the ST_MUL state forms the product term, then a single radix-4
// restoring divider runs twice, first by w + 1 and then by 1000, two quotient bits
// per cycle, and the ST_FIN state loads the output register once it is free.
// sample_ready is high only while the sequencer is idle; a finished word waits
// in the output register while the next sample is taken.
module scaled_exponential_lowpass #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              smoothing_weight_we,
  input  logic [selp_pkg::WEIGHT_BITS-1:0]  smoothing_weight,
  input  logic                              sample_valid,
  output logic                              sample_ready,
  input  logic [SAMPLE_BITS-1:0]            sample,
  output logic                              filtered_valid,
  input  logic                              filtered_ready,
  output logic [SAMPLE_BITS-1:0]            filtered
);
  import selp_pkg::*;

  localparam int RV_W   = SAMPLE_BITS + 10;
  localparam int ACC_W  = SAMPLE_BITS + 21;
  localparam int DIV_W  = ACC_W + (ACC_W % 2);
  localparam int STEPS  = DIV_W / 2;
  localparam int CNT_W  = $clog2(STEPS);
  localparam longint RV_MAX = longint'(SCALE) * ((longint'(1) << SAMPLE_BITS) - 1);

  state_t                   state;
  logic [WEIGHT_BITS-1:0]   weight;
  logic [RV_W-1:0]          running_value;
  logic [SAMPLE_BITS-1:0]   sample_q;
  logic [DIV_W-1:0]         quo;
  logic [DVSR_W-1:0]        rem;
  logic [DVSR_W-1:0]        divisor;
  logic [CNT_W-1:0]         cnt;

  logic [ACC_W-1:0]         acc;
  logic [DIV_W-1:0]         quo_next;
  div_step_t                step1;
  div_step_t                step2;
  logic                     last_step;
  logic                     out_free;

  function automatic div_step_t div_step(input logic [DVSR_W-1:0] r_in,
                                         input logic              bit_in,
                                         input logic [DVSR_W-1:0] d);
    logic [DVSR_W:0] shifted;
    div_step_t       res;
    shifted = {r_in, bit_in};
    if (shifted >= {1'b0, d}) begin
      res.rem  = DVSR_W'(shifted - {1'b0, d});
      res.qbit = 1'b1;
    end else begin
      res.rem  = shifted[DVSR_W-1:0];
      res.qbit = 1'b0;
    end
    return res;
  endfunction

  assign acc = ACC_W'(weight) * ACC_W'(running_value)
             + ACC_W'(SCALE) * ACC_W'(sample_q);

  always_comb begin
    step1    = div_step(rem, quo[DIV_W-1], divisor);
    step2    = div_step(step1.rem, quo[DIV_W-2], divisor);
    quo_next = {quo[DIV_W-3:0], step1.qbit, step2.qbit};
  end

  assign last_step    = (cnt == CNT_W'(STEPS - 1));
  assign out_free     = !filtered_valid || filtered_ready;
  assign sample_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
    end else if (smoothing_weight_we) begin
      weight <= smoothing_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      running_value  <= '0;
      filtered_valid <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) begin
        filtered_valid <= 1'b1;
      end else if (filtered_ready) begin
        filtered_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DIV1;
        end
        ST_DIV1: begin
          if (last_step) begin
            running_value <= quo_next[RV_W-1:0];
            state         <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (last_step) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          sample_q <= sample;
        end
      end
      ST_MUL: begin
        quo     <= DIV_W'(acc);
        rem     <= '0;
        divisor <= DVSR_W'(weight) + DVSR_W'(1);
        cnt     <= '0;
      end
      ST_DIV1: begin
        if (last_step) begin
          quo     <= DIV_W'(quo_next[RV_W-1:0]);
          rem     <= '0;
          divisor <= DVSR_W'(SCALE);
          cnt     <= '0;
        end else begin
          quo <= quo_next;
          rem <= step2.rem;
          cnt <= cnt + CNT_W'(1);
        end
      end
      ST_DIV2: begin
        quo <= quo_next;
        rem <= step2.rem;
        cnt <= cnt + CNT_W'(1);
      end
      ST_FIN: begin
        if (out_free) begin
          filtered <= quo[SAMPLE_BITS-1:0];
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts_mul: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> state == ST_MUL)
    else $error("accepted word did not start the product step");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV1 || state == ST_DIV2) |-> rem < divisor)
    else $error("divider remainder not below divisor");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV1 || state == ST_DIV2) |-> divisor != '0)
    else $error("divider running with zero divisor");

  a_running_in_range: assert property (@(posedge clk) disable iff (rst)
    running_value <= RV_W'(RV_MAX))
    else $error("running value above scaled full range");
`endif

endmodule
